FILE: hdl/pcv_pkg.sv
// pcv_pkg: shared types, constants and tables of the pixel depth converter
// item and result structs, internal command format, luminance rom, index wrap table
// no dependencies
package pcv_pkg;

  // palette size, any value from 16 to 256
  localparam int PalEntries = 256;
  localparam int PalAw      = $clog2(PalEntries);

  typedef logic [PalAw-1:0] pal_addr_t;
  typedef pal_addr_t wrap_lut_t [256];

  // 8-bit pixel index to palette address, wrapping beyond the palette size
  function automatic wrap_lut_t build_wrap_lut();
    wrap_lut_t lut;
    for (int k = 0; k < 256; k++) begin
      lut[k] = pal_addr_t'(k % PalEntries);
    end
    return lut;
  endfunction

  localparam wrap_lut_t WrapLut = build_wrap_lut();

  typedef enum logic [0:0] {
    CFG_GREY_MODE    = 1'b0,
    CFG_NARROW_INDEX = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_PAL_WRITE = 2'd0,
    CMD_PAL_CONV  = 2'd1,
    CMD_GREY_OUT  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic        op;
    logic [31:0] pixels;
    logic [7:0]  palette_index;
    logic [3:0]  red_nibble;
    logic [3:0]  green_nibble;
    logic [3:0]  blue_nibble;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] data;      // pixel word or finished grey word
    pal_addr_t   wr_idx;
    logic [15:0] wr_entry;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // luminance of each 8-bit pixel, top four bits only
  localparam logic [3:0] LumaRom [256] = '{
    4'd0,  4'd0,  4'd0,  4'd1,  4'd2,  4'd2,  4'd3,  4'd3,
    4'd4,  4'd5,  4'd5,  4'd6,  4'd7,  4'd7,  4'd8,  4'd8,
    4'd9,  4'd1,  4'd0,  4'd1,  4'd1,  4'd3,  4'd3,  4'd3,
    4'd4,  4'd5,  4'd6,  4'd6,  4'd6,  4'd8,  4'd8,  4'd9,
    4'd9,  4'd10, 4'd2,  4'd0,  4'd1,  4'd1,  4'd3,  4'd4,
    4'd4,  4'd4,  4'd6,  4'd6,  4'd7,  4'd7,  4'd8,  4'd9,
    4'd9,  4'd10, 4'd11, 4'd3,  4'd0,  4'd1,  4'd1,  4'd4,
    4'd5,  4'd4,  4'd4,  4'd6,  4'd7,  4'd8,  4'd8,  4'd9,
    4'd1,  4'd2,  4'd2,  4'd3,  4'd4,  4'd4,  4'd5,  4'd6,
    4'd6,  4'd7,  4'd7,  4'd8,  4'd9,  4'd9,  4'd10, 4'd1,
    4'd1,  4'd2,  4'd2,  4'd2,  4'd4,  4'd5,  4'd5,  4'd5,
    4'd7,  4'd7,  4'd8,  4'd8,  4'd9,  4'd9,  4'd10, 4'd11,
    4'd11, 4'd1,  4'd2,  4'd2,  4'd3,  4'd5,  4'd6,  4'd5,
    4'd6,  4'd7,  4'd8,  4'd9,  4'd8,  4'd10, 4'd10, 4'd11,
    4'd12, 4'd12, 4'd2,  4'd3,  4'd3,  4'd3,  4'd6,  4'd7,
    4'd6,  4'd6,  4'd8,  4'd9,  4'd9,  4'd9,  4'd10, 4'd11,
    4'd3,  4'd3,  4'd5,  4'd5,  4'd6,  4'd6,  4'd7,  4'd8,
    4'd8,  4'd8,  4'd10, 4'd10, 4'd10, 4'd11, 4'd2,  4'd3,
    4'd3,  4'd3,  4'd4,  4'd5,  4'd6,  4'd6,  4'd6,  4'd8,
    4'd9,  4'd9,  4'd9,  4'd10, 4'd11, 4'd11, 4'd12, 4'd2,
    4'd3,  4'd3,  4'd4,  4'd4,  4'd6,  4'd6,  4'd7,  4'd7,
    4'd9,  4'd10, 4'd10, 4'd10, 4'd11, 4'd12, 4'd12, 4'd13,
    4'd14, 4'd3,  4'd4,  4'd4,  4'd4,  4'd6,  4'd7,  4'd8,
    4'd8,  4'd10, 4'd11, 4'd11, 4'd11, 4'd12, 4'd13, 4'd13,
    4'd5,  4'd6,  4'd6,  4'd7,  4'd7,  4'd8,  4'd9,  4'd9,
    4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd3,  4'd4,  4'd4,
    4'd5,  4'd5,  4'd6,  4'd7,  4'd7,  4'd8,  4'd9,  4'd10,
    4'd10, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13, 4'd4,  4'd4,
    4'd5,  4'd5,  4'd6,  4'd7,  4'd7,  4'd8,  4'd9,  4'd10,
    4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd14, 4'd14, 4'd4,
    4'd4,  4'd5,  4'd5,  4'd6,  4'd7,  4'd8,  4'd9,  4'd9,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd14, 4'd14, 4'd15, 4'd15
  };

endpackage

FILE: hdl/pcv_cmd_queue.sv
// pcv_cmd_queue: two-entry command queue between front and back
// uses pcv_pkg for the command format and status struct
module pcv_cmd_queue import pcv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign cmd_o        = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hdl/pcv_front.sv
// pcv_front: accepts items and configuration writes, classifies items into commands
// holds the grey half word; uses pcv_pkg for the luminance rom and wrap table
module pcv_front import pcv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  input  logic     cfg_we_i,
  input  cfg_reg_e cfg_idx_i,
  input  logic     cfg_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  logic        grey_mode_q;
  logic        narrow_q;
  logic        pending_q, pending_d;
  logic [15:0] low_half_q, low_half_d;
  logic [15:0] nibbles;
  logic [7:0]  idx_m;
  logic        accept;

  assign accept = push_i && !q_full_i;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nibbles[4*k +: 4] = LumaRom[in_i.pixels[8*k +: 8]];
    end
  end

  assign idx_m = narrow_q ? {4'b0000, in_i.palette_index[3:0]} : in_i.palette_index;

  always_comb begin
    q_push_o         = 1'b0;
    q_cmd_o.kind     = CMD_PAL_CONV;
    q_cmd_o.data     = in_i.pixels;
    q_cmd_o.wr_idx   = WrapLut[idx_m];
    q_cmd_o.wr_entry = {in_i.red_nibble, 1'b0, in_i.green_nibble, 2'b00,
                        in_i.blue_nibble, 1'b0};
    pending_d        = pending_q;
    low_half_d       = low_half_q;
    if (accept) begin
      if (in_i.op) begin
        q_cmd_o.kind = CMD_PAL_WRITE;
        q_push_o     = 1'b1;
      end else if (grey_mode_q) begin
        if (pending_q) begin
          q_cmd_o.kind = CMD_GREY_OUT;
          q_cmd_o.data = {nibbles, low_half_q};
          q_push_o     = 1'b1;
          pending_d    = 1'b0;
        end else begin
          // first grey word waits for its partner
          low_half_d = nibbles;
          pending_d  = 1'b1;
        end
      end else begin
        q_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grey_mode_q <= 1'b0;
      narrow_q    <= 1'b0;
      pending_q   <= 1'b0;
      low_half_q  <= 16'h0000;
    end else begin
      pending_q  <= pending_d;
      low_half_q <= low_half_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GREY_MODE:    grey_mode_q <= cfg_data_i;
          CFG_NARROW_INDEX: narrow_q    <= cfg_data_i;
          default:          ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/pcv_back.sv
// pcv_back: carries out commands: palette writes, two-phase palette lookups, grey words
// owns the palette memory and the result queue; uses pcv_pkg
module pcv_back import pcv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_o
);

  localparam int OutDepth = 4;
  localparam int OutAw    = $clog2(OutDepth);

  logic [15:0]      pal_mem [PalEntries];
  logic [15:0]      rd_lo_q, rd_hi_q;
  logic             phase_q, phase_d;
  logic             s_valid_q, s_valid_d;
  logic             s_last_q, s_last_d;
  logic             s_use_mem_q, s_use_mem_d;
  logic [31:0]      s_word_q;
  logic             pal_we, rd_en, space;
  pal_addr_t        addr_lo, addr_hi;

  out_item_t        oq_mem [OutDepth];
  logic [OutAw-1:0] oq_wr_q, oq_rd_q;
  logic [OutAw:0]   oq_cnt_q, oq_cnt_d;
  logic             oq_pop;

  // room for the stage word plus one more issued now
  assign space = (oq_cnt_q + {{OutAw{1'b0}}, s_valid_q}) < (OutAw+1)'(OutDepth);

  assign addr_lo = WrapLut[phase_q ? cmd_i.data[23:16] : cmd_i.data[7:0]];
  assign addr_hi = WrapLut[phase_q ? cmd_i.data[31:24] : cmd_i.data[15:8]];

  always_comb begin
    cmd_pop_o   = 1'b0;
    pal_we      = 1'b0;
    rd_en       = 1'b0;
    phase_d     = phase_q;
    s_valid_d   = 1'b0;
    s_last_d    = 1'b0;
    s_use_mem_d = 1'b0;
    if (!cmd_empty_i) begin
      unique case (cmd_i.kind)
        CMD_PAL_WRITE: begin
          pal_we    = 1'b1;
          cmd_pop_o = 1'b1;
        end
        CMD_PAL_CONV: begin
          if (space) begin
            rd_en       = 1'b1;
            s_valid_d   = 1'b1;
            s_use_mem_d = 1'b1;
            s_last_d    = phase_q;
            cmd_pop_o   = phase_q;
            phase_d     = !phase_q;
          end
        end
        CMD_GREY_OUT: begin
          if (space) begin
            s_valid_d = 1'b1;
            s_last_d  = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        default: cmd_pop_o = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_i.wr_idx] <= cmd_i.wr_entry;
    end
    if (rd_en) begin
      rd_lo_q <= pal_mem[addr_lo];
      rd_hi_q <= pal_mem[addr_hi];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_d && !s_use_mem_d) begin
      s_word_q <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s_valid_q   <= 1'b0;
      s_last_q    <= 1'b0;
      s_use_mem_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      s_valid_q   <= s_valid_d;
      s_last_q    <= s_last_d;
      s_use_mem_q <= s_use_mem_d;
    end
  end

  // result queue
  assign empty_o = (oq_cnt_q == '0);
  assign out_o   = oq_mem[oq_rd_q];
  assign oq_pop  = pop_i && !empty_o;

  always_comb begin
    oq_cnt_d = oq_cnt_q + {{OutAw{1'b0}}, s_valid_q} - {{OutAw{1'b0}}, oq_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (s_valid_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_q) begin
      oq_mem[oq_wr_q].out_word <= s_use_mem_q ? {rd_hi_q, rd_lo_q} : s_word_q;
      oq_mem[oq_wr_q].last     <= s_last_q;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> (oq_cnt_q < (OutAw+1)'(OutDepth)))
    else $error("result queue written while full");

  a_second_phase_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!cmd_empty_i && cmd_i.kind == CMD_PAL_CONV))
    else $error("second lookup phase without a pixel word at the head");

  a_grey_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !s_use_mem_q) |-> s_last_q)
    else $error("grey word not marked last");

  a_phase_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && s_use_mem_q && !s_last_q) |-> phase_q)
    else $error("first palette word not followed by second phase");

endmodule

FILE: hdl/pixel_8bpp_to_16bpp_or_4bpp_convert.sv
// pixel_8bpp_to_16bpp_or_4bpp_convert: top level of the palette / luminance converter
// instantiates pcv_front, pcv_cmd_queue and pcv_back; uses pcv_pkg
//
//   channel   handshake        payload
//   input     push / full      in_item_i  (op, pixels, palette_index, rgb nibbles)
//   result    empty / pop      out_item_o (out_word, last)
//   config    cfg_we_i         cfg_idx_i, cfg_data_i (grey_mode, narrow_index)
//
// a pixel word in palette mode is looked up in a low and a high phase; the back end
// reads two palette entries a cycle, while the result queue has room, through the two
// read ports of the palette memory; palette writes and the second grey word of a pair
// each push one command, while the first grey word of a pair is held in the front
// reset clears queues, config and grey holding state; palette is undefined until written
// front and back stall independently through a two-entry command queue
module pixel_8bpp_to_16bpp_or_4bpp_convert import pcv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_data_i
);

  q_stat_t cmd_stat;
  cmd_t    front_cmd, head_cmd;
  logic    cmd_push, cmd_pop;

  assign full = cmd_stat.full;

  pcv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_i       (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_reg_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (cmd_stat.full),
    .q_push_o   (cmd_push),
    .q_cmd_o    (front_cmd)
  );

  pcv_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (front_cmd),
    .pop_i  (cmd_pop),
    .cmd_o  (head_cmd),
    .stat_o (cmd_stat)
  );

  pcv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (cmd_stat.empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_item_o)
  );

endmodule
